// ----- hw/rtl/stable_sorted_draw_list_core_assert.svh -----
// ----------------------------------------------------------------------------
// stable sorted draw list assertion macros
// shared property forms for the list core checks
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_DRAW_LIST_CORE_ASSERT_SVH
`define STABLE_SORTED_DRAW_LIST_CORE_ASSERT_SVH

// same-cycle implication
`define SSDL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssdl assertion failed");

// next-cycle implication
`define SSDL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssdl assertion failed");

`endif

// ----- hw/rtl/ssdl_pkg.sv -----
// ----------------------------------------------------------------------------
// ssdl_pkg
// constants, codes and types shared by the sorted draw list cells and core
// ----------------------------------------------------------------------------
package ssdl_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int KEY_LIMIT   = 1000000;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W = 20;
  localparam int ID_W  = 8;
  localparam int CMD_W = 3;
  localparam int ST_W  = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REWIND  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 3'd2;
  localparam logic [ST_W-1:0] ST_DUP     = 3'd3;
  localparam logic [ST_W-1:0] ST_END     = 3'd4;

  localparam logic [KEY_W-1:0] KEY_SAT = KEY_W'(KEY_LIMIT - 1);

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_REM
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [KEY_W-1:0]       key;
    logic [ID_W-1:0]        id;
    logic [IDX_W-1:0]       rm_idx;
    logic [CNT_W-1:0]       count;
  } cell_ctl_t;

  function automatic logic [IDX_W-1:0] onehot_to_idx(input logic [MAX_ENTRIES-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (v[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- hw/rtl/ssdl_cell.sv -----
// ----------------------------------------------------------------------------
// ssdl_cell
// one list slot: holds an entry, compares it with the broadcast item and
// takes the item or its left neighbor on insert, or its right neighbor on remove
// ----------------------------------------------------------------------------
module ssdl_cell
  import ssdl_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic             left_le,
  input  logic [KEY_W-1:0] left_key,
  input  logic [ID_W-1:0]  left_id,
  input  logic [KEY_W-1:0] right_key,
  input  logic [ID_W-1:0]  right_id,
  output logic [KEY_W-1:0] key,
  output logic [ID_W-1:0]  id,
  output logic             le,
  output logic             match
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic             occ;

  assign occ   = CNT_W'(cell_idx) < ctl.count;
  assign le    = occ && (key_r <= ctl.key);
  assign match = occ && (id_r == ctl.id);
  assign key   = key_r;
  assign id    = id_r;

  always_comb begin
    key_nxt = key_r;
    id_nxt  = id_r;
    unique case (ctl.op)
      OP_INS: begin
        if (!le) begin
          if (left_le) begin
            key_nxt = ctl.key;
            id_nxt  = ctl.id;
          end else begin
            key_nxt = left_key;
            id_nxt  = left_id;
          end
        end
      end
      OP_REM: begin
        if (cell_idx >= ctl.rm_idx) begin
          key_nxt = right_key;
          id_nxt  = right_id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    id_r  <= id_nxt;
  end

endmodule

// ----- hw/rtl/stable_sorted_draw_list_core.sv -----
// ----------------------------------------------------------------------------
// stable_sorted_draw_list_core
// sorted entry list with stable insert, remove by id and an in-order iterator
// ----------------------------------------------------------------------------
// The list sits in a row of MAX_ENTRIES slot cells. For every command, each
// cell compares its entry with the item in parallel and, in the same edge,
// takes the item or its left neighbor on insert, its right one on remove. A
// new item is accepted every cycle as long as the result register is free or
// its result is taken in that cycle, so the sustained rate is one item per
// cycle. The result appears in the next cycle. Entries tie-break in arrival
// order, keys at or above KEY_LIMIT are stored as KEY_LIMIT-1, and duplicate,
// full and missing-id commands leave the list unchanged and report a status.
`include "stable_sorted_draw_list_core_assert.svh"

module stable_sorted_draw_list_core
  import ssdl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [ID_W-1:0]  in_entry_id,
  input  logic [KEY_W-1:0] in_entry_key,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ST_W-1:0]  out_status,
  output logic             out_has_item,
  output logic [ID_W-1:0]  out_item_id,
  output logic [KEY_W-1:0] out_item_key,
  output logic [CNT_W-1:0] out_entry_count
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] iter_r, iter_nxt;
  logic             out_valid_r;
  logic [ST_W-1:0]  status_r, status_nxt;
  logic             has_r, has_nxt;
  logic [ID_W-1:0]  oid_r, oid_nxt;
  logic [KEY_W-1:0] okey_r, okey_nxt;

  logic                   accept;
  logic [KEY_W-1:0]       key_sat;
  cell_ctl_t              ctl;
  logic [KEY_W-1:0]       cell_key [MAX_ENTRIES];
  logic [ID_W-1:0]        cell_id  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] le_vec;
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES-1:0] left_le_vec;
  logic [MAX_ENTRIES-1:0] ins_vec;
  logic [IDX_W-1:0]       ins_pos;
  logic [IDX_W-1:0]       rm_pos;
  logic                   found;
  logic                   ins_ok;
  logic                   rem_ok;
  logic [KEY_W-1:0]       rd_key;
  logic [ID_W-1:0]        rd_id;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign key_sat = (32'(in_entry_key) >= 32'(KEY_LIMIT)) ? KEY_SAT : in_entry_key;

  assign found   = |match_vec;
  assign ins_vec = ~le_vec & left_le_vec;
  assign ins_pos = onehot_to_idx(ins_vec);
  assign rm_pos  = onehot_to_idx(match_vec);

  assign ins_ok = accept && (in_cmd == CMD_INSERT) && !found && (count_r < CNT_W'(MAX_ENTRIES));
  assign rem_ok = accept && (in_cmd == CMD_REMOVE) && found;

  always_comb begin
    ctl.key    = key_sat;
    ctl.id     = in_entry_id;
    ctl.rm_idx = rm_pos;
    ctl.count  = count_r;
    if (ins_ok) begin
      ctl.op = OP_INS;
    end else if (rem_ok) begin
      ctl.op = OP_REM;
    end else begin
      ctl.op = OP_HOLD;
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_le_vec[g] = 1'b1;
    end else begin : g_rest
      assign left_le_vec[g] = le_vec[g-1];
    end

    ssdl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cell_idx  (IDX_W'(g)),
      .left_le   (left_le_vec[g]),
      .left_key  ((g == 0) ? cell_key[g] : cell_key[(g == 0) ? 0 : g-1]),
      .left_id   ((g == 0) ? cell_id[g] : cell_id[(g == 0) ? 0 : g-1]),
      .right_key (cell_key[(g == MAX_ENTRIES-1) ? g : g+1]),
      .right_id  (cell_id[(g == MAX_ENTRIES-1) ? g : g+1]),
      .key       (cell_key[g]),
      .id        (cell_id[g]),
      .le        (le_vec[g]),
      .match     (match_vec[g])
    );
  end

  // iterator read
  always_comb begin
    rd_key = '0;
    rd_id  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (iter_r == CNT_W'(i)) begin
        rd_key = rd_key | cell_key[i];
        rd_id  = rd_id | cell_id[i];
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    iter_nxt   = iter_r;
    status_nxt = ST_OK;
    has_nxt    = 1'b0;
    oid_nxt    = '0;
    okey_nxt   = '0;
    unique case (in_cmd)
      CMD_INSERT: begin
        if (found) begin
          status_nxt = ST_DUP;
        end else if (count_r >= CNT_W'(MAX_ENTRIES)) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          if (iter_r > CNT_W'(ins_pos)) begin
            iter_nxt = iter_r + CNT_W'(1);
          end
        end
      end
      CMD_REMOVE: begin
        if (!found) begin
          status_nxt = ST_MISSING;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          if (iter_r > CNT_W'(rm_pos)) begin
            iter_nxt = iter_r - CNT_W'(1);
          end
        end
      end
      CMD_ADVANCE: begin
        if (iter_r < count_r) begin
          has_nxt  = 1'b1;
          oid_nxt  = rd_id;
          okey_nxt = rd_key;
          iter_nxt = iter_r + CNT_W'(1);
        end else begin
          iter_nxt   = '0;
          status_nxt = ST_END;
        end
      end
      CMD_REWIND: begin
        iter_nxt = '0;
      end
      CMD_CLEAR: begin
        count_nxt = '0;
        iter_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        iter_r      <= iter_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      has_r    <= has_nxt;
      oid_r    <= oid_nxt;
      okey_r   <= okey_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_has_item    = has_r;
  assign out_item_id     = oid_r;
  assign out_item_key    = okey_r;
  assign out_entry_count = count_r;

  `SSDL_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_ENTRIES))
  `SSDL_ASSERT_IMP(a_iter_range, clk, rst_n, 1'b1, iter_r <= count_r)
  `SSDL_ASSERT_IMP(a_id_unique, clk, rst_n, 1'b1, $onehot0(match_vec))
  `SSDL_ASSERT_NXT(a_dup_keeps, clk, rst_n, accept && (in_cmd == CMD_INSERT) && found, count_r == $past(count_r))

endmodule

// ----- tb/ssdl_list_checker.sv -----
// ----------------------------------------------------------------------------
// ssdl_list_checker
// watches both channels of the sorted draw list core, keeps its own copy of
// the ordered list and iterator, and compares every result item field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssdl_list_checker
  import ssdl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [ID_W-1:0]  in_entry_id,
  input  logic [KEY_W-1:0] in_entry_key,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [ST_W-1:0]  out_status,
  input  logic             out_has_item,
  input  logic [ID_W-1:0]  out_item_id,
  input  logic [KEY_W-1:0] out_item_key,
  input  logic [CNT_W-1:0] out_entry_count,
  output int               fail_count,
  output int               outstanding
);

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             has_item;
    logic [ID_W-1:0]  item_id;
    logic [KEY_W-1:0] item_key;
    logic [CNT_W-1:0] entry_count;
  } list_result_t;

  logic [KEY_W-1:0] row_keys [MAX_ENTRIES];
  logic [ID_W-1:0]  row_ids  [MAX_ENTRIES];
  int               row_len = 0;
  int               cursor  = 0;
  list_result_t     awaited_results [$];

  // apply one command to the shadow list and return the result it gives
  function automatic list_result_t step_list(input logic [CMD_W-1:0] cmd,
                                             input logic [ID_W-1:0]  id,
                                             input logic [KEY_W-1:0] key);
    list_result_t     res;
    int               hit;
    int               pos;
    logic [KEY_W-1:0] k;
    res = '0;
    res.status = ST_OK;
    hit = -1;
    for (int i = 0; i < row_len; i++) begin
      if (hit < 0 && row_ids[i] == id) hit = i;
    end
    case (cmd)
      CMD_INSERT: begin
        if (hit >= 0) begin
          res.status = ST_DUP;
        end else if (row_len >= MAX_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          k = (key >= KEY_LIMIT) ? KEY_SAT : key;
          pos = 0;
          while (pos < row_len && row_keys[pos] <= k) pos++;
          for (int i = row_len; i > pos; i--) begin
            row_keys[i] = row_keys[i-1];
            row_ids[i]  = row_ids[i-1];
          end
          row_keys[pos] = k;
          row_ids[pos]  = id;
          row_len++;
          if (cursor > pos) cursor++;
        end
      end
      CMD_REMOVE: begin
        if (hit < 0) begin
          res.status = ST_MISSING;
        end else begin
          for (int i = hit; i + 1 < row_len; i++) begin
            row_keys[i] = row_keys[i+1];
            row_ids[i]  = row_ids[i+1];
          end
          row_len--;
          if (cursor > hit) cursor--;
        end
      end
      CMD_ADVANCE: begin
        if (cursor >= row_len) begin
          cursor = 0;
          res.status = ST_END;
        end else begin
          res.has_item = 1'b1;
          res.item_id  = row_ids[cursor];
          res.item_key = row_keys[cursor];
          cursor++;
        end
      end
      CMD_REWIND: begin
        cursor = 0;
      end
      CMD_CLEAR: begin
        row_len = 0;
        cursor  = 0;
      end
      default: ;
    endcase
    res.entry_count = CNT_W'(row_len);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    list_result_t want;
    if (!rst_n) begin
      row_len    = 0;
      cursor     = 0;
      fail_count = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("has_item", 32'(want.has_item), 32'(out_has_item));
          check_field("item_id", 32'(want.item_id), 32'(out_item_id));
          check_field("item_key", 32'(want.item_key), 32'(out_item_key));
          check_field("entry_count", 32'(want.entry_count), 32'(out_entry_count));
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(step_list(in_cmd, in_entry_id, in_entry_key));
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

// ----- tb/tb_stable_sorted_draw_list_core.sv -----
// ----------------------------------------------------------------------------
// tb_stable_sorted_draw_list_core
// drives directed and random list commands into the sorted draw list core
// with random gaps and output stalls; a side checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stable_sorted_draw_list_core;
  import ssdl_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum int {MIX_FILL, MIX_CHURN, MIX_WALK, MIX_DRAIN} mix_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] in_cmd = CMD_REWIND;
  logic [ID_W-1:0]  in_entry_id = '0;
  logic [KEY_W-1:0] in_entry_key = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ST_W-1:0]  out_status;
  logic             out_has_item;
  logic [ID_W-1:0]  out_item_id;
  logic [KEY_W-1:0] out_item_key;
  logic [CNT_W-1:0] out_entry_count;
  int               fail_count;
  int               outstanding;
  int               cycles = 0;
  bit               calm = 1'b0;

  always #5 clk = ~clk;

  stable_sorted_draw_list_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_entry_id     (in_entry_id),
    .in_entry_key    (in_entry_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_has_item    (out_has_item),
    .out_item_id     (out_item_id),
    .out_item_key    (out_item_key),
    .out_entry_count (out_entry_count)
  );

  ssdl_list_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_entry_id     (in_entry_id),
    .in_entry_key    (in_entry_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_has_item    (out_has_item),
    .out_item_id     (out_item_id),
    .out_item_key    (out_item_key),
    .out_entry_count (out_entry_count),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 8);
  end

  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [KEY_W-1:0] key);
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_entry_id  <= id;
    in_entry_key <= key;
    do @(posedge clk); while (!in_ready);
  endtask

  // many small keys so ties are common, some near and above the limit
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return KEY_W'($urandom_range(0, 7));
    if (r < 8) return KEY_W'($urandom_range(0, KEY_LIMIT - 1));
    if (r == 8) return KEY_W'($urandom_range(KEY_LIMIT - 10, (1 << KEY_W) - 1));
    return KEY_W'($urandom());
  endfunction

  initial begin
    mix_t             mix;
    int               roll;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;

    mix = MIX_FILL;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    push_item(CMD_ADVANCE, 8'h00, '0);
    push_item(CMD_REMOVE, 8'hFF, '0);
    push_item(CMD_REWIND, 8'h00, '0);
    push_item(CMD_INSERT, 8'h00, '0);
    push_item(CMD_INSERT, 8'hFF, '1);
    push_item(CMD_INSERT, 8'h55, KEY_W'(KEY_LIMIT - 1));
    push_item(CMD_INSERT, 8'hAA, KEY_W'(KEY_LIMIT));
    push_item(CMD_INSERT, 8'h00, KEY_W'(5));
    push_item(CMD_INSERT, 8'h01, '0);
    push_item(CMD_ADVANCE, 8'h00, '0);
    push_item(CMD_ADVANCE, 8'h00, '0);
    push_item(CMD_REMOVE, 8'h01, '0);
    push_item(CMD_INSERT, 8'h02, '0);
    push_item(CMD_ADVANCE, 8'h00, '0);
    push_item(CMD_REMOVE, 8'h00, '0);
    repeat (4) push_item(CMD_ADVANCE, 8'h00, '0);
    for (int c = CMD_CLEAR + 1; c < (1 << CMD_W); c++) begin
      push_item(CMD_W'(c), '1, '1);
    end
    push_item(CMD_ADVANCE, 8'h00, '0);
    push_item(CMD_REMOVE, 8'h02, '0);
    push_item(CMD_CLEAR, 8'h00, '0);

    // random
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 80 == 0) mix = (n == 0) ? MIX_FILL : mix_t'($urandom_range(0, 3));
      calm = (n >= 240 && n < 340);
      roll = $urandom_range(0, 99);
      id   = ID_W'($urandom_range(0, 255));
      case (mix)
        MIX_FILL: begin
          cmd = (roll < 92) ? CMD_INSERT : (roll < 96) ? CMD_ADVANCE :
                (roll < 99) ? CMD_REMOVE : CMD_REWIND;
        end
        MIX_CHURN: begin
          id  = ID_W'($urandom_range(0, 15));
          cmd = (roll < 40) ? CMD_INSERT : (roll < 75) ? CMD_REMOVE :
                (roll < 95) ? CMD_ADVANCE : CMD_REWIND;
        end
        MIX_WALK: begin
          id  = ID_W'($urandom_range(0, 63));
          cmd = (roll < 20) ? CMD_INSERT : (roll < 40) ? CMD_REMOVE :
                (roll < 95) ? CMD_ADVANCE : CMD_REWIND;
        end
        default: begin
          cmd = (roll < 60) ? CMD_REMOVE : (roll < 90) ? CMD_ADVANCE :
                (roll < 97) ? CMD_INSERT : CMD_REWIND;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (mix != MIX_FILL && roll < 2) cmd = CMD_CLEAR;
      else if (roll == 2) cmd = CMD_W'($urandom_range(CMD_CLEAR + 1, (1 << CMD_W) - 1));
      push_item(cmd, id, pick_key());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
